// File: src/hkit_pkg.sv
// Shared types and constants of the hash-keyed intern table.
`timescale 1ns / 1ps

package hkit_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int KEY_W           = 64;
	localparam int HANDLE_W        = 32;
	localparam int STATUS_W        = 2;
	localparam int SLOT_IDX_W      = 6;
	localparam int FILL_W          = 7;
	localparam logic [FILL_W-1:0] FILL_RESET = 7'd44;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_FILL_LIMIT = 1'd0;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 2'd0,
		ST_INSERTED  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                used;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} slot_word_t;

endpackage

// File: src/hkit_if.sv
// Request and response channel interfaces of the hash-keyed intern table.
`timescale 1ns / 1ps

interface hkit_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [hkit_pkg::KEY_W-1:0]    key_hash;
	logic [hkit_pkg::HANDLE_W-1:0] value_handle;

	modport source (output valid, cmd, key_hash, value_handle, input ready);
	modport sink (input valid, cmd, key_hash, value_handle, output ready);
endinterface

interface hkit_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [hkit_pkg::STATUS_W-1:0]   status;
	logic [hkit_pkg::HANDLE_W-1:0]   found_handle;
	logic [hkit_pkg::SLOT_IDX_W-1:0] slot_index;
	logic                            over_limit;

	modport source (output valid, status, found_handle, slot_index, over_limit, input ready);
	modport sink (input valid, status, found_handle, slot_index, over_limit, output ready);
endinterface

// File: src/hkit_cfg.sv
// APB configuration register block: fill limit.
`timescale 1ns / 1ps

module hkit_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hkit_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [hkit_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [hkit_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic [hkit_pkg::FILL_W-1:0]       fill_limit
);

	logic [hkit_pkg::FILL_W-1:0]    fill_limit_q;
	logic [hkit_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_word;

	assign reg_idx = paddr[hkit_pkg::APB_ADDR_W-1:2];
	assign wr_word = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_limit_q <= hkit_pkg::FILL_RESET;
		end else if (wr_word && reg_idx == hkit_pkg::REG_FILL_LIMIT) begin
			fill_limit_q <= pwdata[hkit_pkg::FILL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			hkit_pkg::REG_FILL_LIMIT: begin
				prdata = hkit_pkg::APB_DATA_W'(fill_limit_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign fill_limit = fill_limit_q;

endmodule

// File: src/hkit_slot_ram.sv
// Single-port-per-direction slot memory with registered read data.
`timescale 1ns / 1ps

module hkit_slot_ram #(
	parameter int DEPTH = hkit_pkg::TABLE_SLOTS_DEF,
	parameter int WIDTH = $bits(hkit_pkg::slot_word_t)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/hkit_probe.sv
// Probe sequencer: clearing pass, hash reduction, linear probe, insert and result register.
`timescale 1ns / 1ps

module hkit_probe #(
	parameter int TABLE_SLOTS = hkit_pkg::TABLE_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hkit_req_if.sink                       req,
	hkit_rsp_if.source                     rsp,
	input  logic [hkit_pkg::FILL_W-1:0]    fill_limit,
	output logic                           rd_en,
	output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	output logic                           wr_en,
	output logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
	output hkit_pkg::slot_word_t           wr_data,
	input  hkit_pkg::slot_word_t           rd_data
);

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam int CMP_W   = (CNT_W > hkit_pkg::FILL_W) ? CNT_W : hkit_pkg::FILL_W;
	localparam bit IS_POW2 = (TABLE_SLOTS == (1 << IDX_W));
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
	localparam int FOLD_W = 18 + IDX_W;
	localparam int RCP_W  = FOLD_W - IDX_W + 1;
	localparam int PROD_W = FOLD_W + RCP_W;
	localparam logic [FOLD_W-1:0] FOLD_R1    = FOLD_W'((64'd1 << 16) % TABLE_SLOTS);
	localparam logic [FOLD_W-1:0] FOLD_R2    = FOLD_W'((64'd1 << 32) % TABLE_SLOTS);
	localparam logic [FOLD_W-1:0] FOLD_R3    = FOLD_W'((64'd1 << 48) % TABLE_SLOTS);
	localparam logic [FOLD_W-1:0] SLOTS_FOLD = FOLD_W'(TABLE_SLOTS);
	localparam logic [PROD_W-1:0] RECIP      = PROD_W'((64'd1 << FOLD_W) / TABLE_SLOTS);
	localparam logic [1:0]        MOD_LAST   = 2'd3;

	hkit_pkg::state_t state_q, state_nxt;

	logic [IDX_W-1:0]                  clr_q;
	logic                              cmd_q;
	logic [hkit_pkg::KEY_W-1:0]        key_q;
	logic [hkit_pkg::HANDLE_W-1:0]     handle_q;
	logic [IDX_W-1:0]                  pos_q;
	logic [IDX_W-1:0]                  tries_q;
	logic [1:0]                        mod_step_q;
	logic [FOLD_W-1:0]                 fold_q;
	logic [RCP_W-1:0]                  quot_q;
	logic [IDX_W:0]                    rem_q;
	logic [CNT_W-1:0]                  count_q;
	hkit_pkg::status_t                 res_status_q;
	logic [hkit_pkg::HANDLE_W-1:0]     res_handle_q;
	logic [IDX_W-1:0]                  res_slot_q;
	logic                              rsp_valid_q;
	hkit_pkg::status_t                 rsp_status_q;
	logic [hkit_pkg::HANDLE_W-1:0]     rsp_handle_q;
	logic [hkit_pkg::SLOT_IDX_W-1:0]   rsp_slot_q;
	logic                              rsp_over_q;

	logic              accept;
	logic              hit;
	logic              empty;
	logic              exhausted;
	logic              out_free;
	logic [IDX_W-1:0]  pos_inc;
	logic [FOLD_W-1:0] fold_p1;
	logic [FOLD_W-1:0] fold_p2;
	logic [FOLD_W-1:0] fold_p3;
	logic [FOLD_W-1:0] fold_sum;
	logic [PROD_W-1:0] quot_prod;
	logic [FOLD_W-1:0] quot_back;
	logic [IDX_W-1:0]  rem_fix;

	assign accept    = req.valid && (state_q == hkit_pkg::S_IDLE);
	assign hit       = rd_data.used && (rd_data.key == key_q);
	assign empty     = !rd_data.used;
	assign exhausted = (tries_q == LAST_SLOT);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign pos_inc   = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;

	// hash reduction: fold 16-bit chunks by 2^16k mod N, reciprocal quotient, one correction
	assign fold_p1   = FOLD_W'(key_q[31:16]) * FOLD_R1;
	assign fold_p2   = FOLD_W'(key_q[47:32]) * FOLD_R2;
	assign fold_p3   = FOLD_W'(key_q[63:48]) * FOLD_R3;
	assign fold_sum  = FOLD_W'(key_q[15:0]) + fold_p1 + fold_p2 + fold_p3;
	assign quot_prod = PROD_W'(fold_q) * RECIP;
	assign quot_back = FOLD_W'(quot_q) * SLOTS_FOLD;
	assign rem_fix   = (rem_q >= SLOTS_EXT) ? IDX_W'(rem_q - SLOTS_EXT) : IDX_W'(rem_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hkit_pkg::S_CLEAR: begin
				if (clr_q == LAST_SLOT) state_nxt = hkit_pkg::S_IDLE;
			end
			hkit_pkg::S_IDLE: begin
				if (req.valid) state_nxt = IS_POW2 ? hkit_pkg::S_READ : hkit_pkg::S_MOD;
			end
			hkit_pkg::S_MOD: begin
				if (mod_step_q == MOD_LAST) state_nxt = hkit_pkg::S_READ;
			end
			hkit_pkg::S_READ: begin
				state_nxt = hkit_pkg::S_CHECK;
			end
			hkit_pkg::S_CHECK: begin
				if (hit || empty || exhausted) state_nxt = hkit_pkg::S_RESP;
			end
			hkit_pkg::S_RESP: begin
				if (out_free) state_nxt = hkit_pkg::S_IDLE;
			end
			default: begin
				state_nxt = hkit_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = '0;
		case (state_q)
			hkit_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			hkit_pkg::S_IDLE: begin
				req.ready = 1'b1;
			end
			hkit_pkg::S_READ: begin
				rd_en = 1'b1;
			end
			hkit_pkg::S_CHECK: begin
				if (empty && cmd_q == hkit_pkg::CMD_INSERT) begin
					wr_en          = 1'b1;
					wr_data.used   = 1'b1;
					wr_data.key    = key_q;
					wr_data.handle = handle_q;
				end else if (!hit && !empty && !exhausted) begin
					rd_en   = 1'b1;
					rd_addr = pos_inc;
				end
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hkit_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == hkit_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == hkit_pkg::S_CHECK && empty && cmd_q == hkit_pkg::CMD_INSERT) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == hkit_pkg::S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= req.cmd;
			key_q      <= req.key_hash;
			handle_q   <= req.value_handle;
			pos_q      <= IS_POW2 ? req.key_hash[IDX_W-1:0] : '0;
			tries_q    <= '0;
			mod_step_q <= '0;
		end
		if (state_q == hkit_pkg::S_MOD) begin
			mod_step_q <= mod_step_q + 1'b1;
			fold_q     <= fold_sum;
			quot_q     <= quot_prod[PROD_W-1:FOLD_W];
			rem_q      <= (IDX_W + 1)'(fold_q - quot_back);
			if (mod_step_q == MOD_LAST) pos_q <= rem_fix;
		end
		if (state_q == hkit_pkg::S_CHECK) begin
			if (hit) begin
				res_status_q <= hkit_pkg::ST_FOUND;
				res_handle_q <= rd_data.handle;
				res_slot_q   <= pos_q;
			end else if (empty && cmd_q == hkit_pkg::CMD_INSERT) begin
				res_status_q <= hkit_pkg::ST_INSERTED;
				res_handle_q <= handle_q;
				res_slot_q   <= pos_q;
			end else if (empty) begin
				res_status_q <= hkit_pkg::ST_NOT_FOUND;
				res_handle_q <= '0;
				res_slot_q   <= '0;
			end else if (exhausted) begin
				res_status_q <= hkit_pkg::ST_FULL;
				res_handle_q <= '0;
				res_slot_q   <= '0;
			end else begin
				pos_q   <= pos_inc;
				tries_q <= tries_q + 1'b1;
			end
		end
		if (state_q == hkit_pkg::S_RESP && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_handle_q <= res_handle_q;
			rsp_slot_q   <= hkit_pkg::SLOT_IDX_W'(res_slot_q);
			rsp_over_q   <= CMP_W'(count_q) > CMP_W'(fill_limit);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.found_handle = rsp_handle_q;
	assign rsp.slot_index   = rsp_slot_q;
	assign rsp.over_limit   = rsp_over_q;

endmodule

// File: src/hash_keyed_intern_table.sv
// Hash-keyed intern table: linear-probing slot store with APB fill-limit register.
// Each word probes from 1 to TABLE_SLOTS slots, one probe per cycle through the slot memory read port.
// Words are taken one at a time: a new word is accepted only in idle, once the last result is registered.
// Sizes that are not a power of two add a hash reduction (S_MOD) before the probe of each word.
// Reset: a clearing pass zeroes the slot memory; no word is taken meanwhile.
`timescale 1ns / 1ps

module hash_keyed_intern_table #(
	parameter int TABLE_SLOTS = hkit_pkg::TABLE_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hkit_req_if.sink                        req,
	hkit_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hkit_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hkit_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hkit_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);

	logic [hkit_pkg::FILL_W-1:0] fill_limit;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	hkit_pkg::slot_word_t        wr_data;
	hkit_pkg::slot_word_t        rd_data;

	hkit_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fill_limit (fill_limit)
	);

	hkit_slot_ram #(
		.DEPTH (TABLE_SLOTS),
		.WIDTH ($bits(hkit_pkg::slot_word_t))
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hkit_probe #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_probe (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fill_limit (fill_limit),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data    (rd_data)
	);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the hash-keyed intern table: directed and random words, scoreboarded.
`timescale 1ns / 1ps

module testbench;
	import hkit_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_FILL_LIMIT + 1'b1;
	localparam logic [APB_ADDR_W-1:0] ADDR_FILL_LIMIT = {REG_FILL_LIMIT, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};

	typedef struct {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic [SLOT_IDX_W-1:0] slot;
		logic                  over;
	} reply_t;

	class intern_scoreboard;
		bit                  used[SLOTS];
		logic [KEY_W-1:0]    keys[SLOTS];
		logic [HANDLE_W-1:0] handles[SLOTS];
		int unsigned         entries;
		logic [FILL_W-1:0]   fill_limit;
		reply_t              replies[$];
		int unsigned         failures;

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				keys[i] = '0;
				handles[i] = '0;
			end
			entries = 0;
			fill_limit = FILL_RESET;
			failures = 0;
		endfunction

		function int pending();
			return replies.size();
		endfunction

		// linear probe from the home slot, one reply per request word
		function void note_request(cmd_t op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
			int unsigned pos;
			reply_t      r;
			pos = 32'(key % SLOTS);
			r.status = ST_FULL;
			r.handle = '0;
			r.slot = '0;
			for (int n = 0; n < SLOTS; n++) begin
				if (used[pos]) begin
					if (keys[pos] == key) begin
						r.status = ST_FOUND;
						r.handle = handles[pos];
						r.slot = pos[SLOT_IDX_W-1:0];
						break;
					end
				end else begin
					if (op == CMD_INSERT) begin
						used[pos] = 1'b1;
						keys[pos] = key;
						handles[pos] = handle;
						entries++;
						r.status = ST_INSERTED;
						r.handle = handle;
						r.slot = pos[SLOT_IDX_W-1:0];
					end else begin
						r.status = ST_NOT_FOUND;
					end
					break;
				end
				pos = (pos + 1) % SLOTS;
			end
			r.over = (entries > fill_limit);
			replies.push_back(r);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
			logic [SLOT_IDX_W-1:0] slot, logic over);
			reply_t want;
			if (replies.size() == 0) begin
				$error("result word with no request outstanding");
				failures++;
				return;
			end
			want = replies.pop_front();
			if (status !== want.status) begin
				$error("status: expected %s, got %0d", want.status.name(), status);
				failures++;
			end
			if (handle !== want.handle) begin
				$error("found_handle: expected %h, got %h", want.handle, handle);
				failures++;
			end
			if (slot !== want.slot) begin
				$error("slot_index: expected %0d, got %0d", want.slot, slot);
				failures++;
			end
			if (over !== want.over) begin
				$error("over_limit: expected %0b, got %0b", want.over, over);
				failures++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	hkit_req_if req ();
	hkit_rsp_if rsp ();

	hash_keyed_intern_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	intern_scoreboard model = new();
	logic [KEY_W-1:0] known_keys[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("hash_keyed_intern_table verification failed");
		$finish;
	end

	// result side: check accepted words, then choose ready for the next edge
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				model.check_reply(rsp.status, rsp.found_handle, rsp.slot_index, rsp.over_limit);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(cmd_t op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.key_hash <= key;
		req.value_handle <= handle;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		model.note_request(op, key, handle);
	endtask

	task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_FILL_LIMIT)
			model.fill_limit = data[FILL_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_fill_limit();
		logic [APB_DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FILL_LIMIT;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[FILL_W-1:0] !== model.fill_limit) begin
			$error("fill_limit: expected %0d, got %0d", model.fill_limit, got[FILL_W-1:0]);
			model.failures++;
		end
		@(posedge clk);
	endtask

	// drain before touching the register; one word is always one reply
	task automatic settle();
		req.valid <= 1'b0;
		while (model.pending() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic set_fill_limit(logic [APB_DATA_W-1:0] value);
		settle();
		reg_write(ADDR_FILL_LIMIT, value);
		check_fill_limit();
	endtask

	// most keys share a few home slots so clusters and wrap-around form
	function automatic logic [KEY_W-1:0] clustered_key();
		logic [KEY_W-1:0] k;
		k = {$urandom, $urandom};
		if ($urandom_range(99) < 60) begin
			case ($urandom_range(3))
				0: k[5:0] = 6'd62;
				1: k[5:0] = 6'd63;
				2: k[5:0] = 6'd0;
				default: k[5:0] = 6'd30;
			endcase
		end
		return k;
	endfunction

	task automatic random_words(int count, int fresh_per_mille);
		logic [KEY_W-1:0] key;
		int unsigned      pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if ($urandom_range(999) < fresh_per_mille || known_keys.size() == 0) begin
				key = clustered_key();
				known_keys.push_back(key);
				send_word(CMD_INSERT, key, $urandom);
			end else if (pick < 35) begin
				send_word(CMD_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)], $urandom);
			end else if (pick < 60) begin
				send_word(CMD_INSERT, known_keys[$urandom_range(known_keys.size() - 1)], $urandom);
			end else if (pick < 88) begin
				send_word(CMD_LOOKUP, clustered_key(), $urandom);
			end else begin
				send_word(CMD_LOOKUP, {$urandom, $urandom}, $urandom);
			end
		end
	endtask

	initial begin
		int drain;
		req.valid <= 1'b0;
		req.cmd <= CMD_LOOKUP;
		req.key_hash <= '0;
		req.value_handle <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FILL_LIMIT;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_fill_limit();

		// empty table, zero handle, extremes, collisions and wrap past the last slot
		send_word(CMD_LOOKUP, 64'h0, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 64'h0, 32'h0);
		send_word(CMD_LOOKUP, 64'h0, 32'h1234_5678);
		send_word(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 64'h40, 32'hA5A5_A5A5);
		send_word(CMD_INSERT, 64'h80, 32'h5A5A_5A5A);
		send_word(CMD_INSERT, 64'h7F, 32'h0000_0001);
		send_word(CMD_LOOKUP, 64'hBF, 32'h0);
		send_word(CMD_INSERT, 64'h40, 32'hDEAD_0000);
		send_word(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_word(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
		send_word(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		send_word(CMD_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		known_keys.push_back(64'h0);
		known_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		known_keys.push_back(64'h40);

		// limit of zero flags any entry; the unmapped register must not disturb it
		settle();
		reg_write(ADDR_FILL_LIMIT, 32'd0);
		reg_write(ADDR_UNMAPPED, 32'h0000_0055);
		check_fill_limit();
		send_word(CMD_LOOKUP, 64'h0, 32'h0);
		send_word(CMD_INSERT, 64'h1234_5678_9ABC_DEF0, 32'h0BAD_F00D);
		known_keys.push_back(64'h1234_5678_9ABC_DEF0);

		set_fill_limit($urandom_range(12, 30));
		send_idle_pct = 37;
		recv_idle_pct = 87;
		random_words(400, 40);

		set_fill_limit(32'd1);
		send_idle_pct = 87;
		recv_idle_pct = 37;
		random_words(400, 40);

		// no idling; a long result stall backs the table up, then it fills completely
		set_fill_limit(32'd63);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 400;
		random_words(420, 100);

		set_fill_limit(SLOTS);
		random_words(20, 100);

		set_fill_limit(32'hFFFF_FFFF);
		random_words(20, 100);

		req.valid <= 1'b0;
		drain = 0;
		while (model.pending() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (80) @(posedge clk);
		if (model.pending() != 0) begin
			$error("%0d expected result words never arrived", model.pending());
			model.failures++;
		end
		if (model.failures == 0)
			$display("hash_keyed_intern_table verification clean");
		else
			$display("hash_keyed_intern_table verification failed");
		$finish;
	end

endmodule

// File: files.f
src/hkit_pkg.sv
src/hkit_if.sv
src/hkit_cfg.sv
src/hkit_slot_ram.sv
src/hkit_probe.sv
src/hash_keyed_intern_table.sv
tb/sv/testbench.sv
